### rtl/core/shr_pkg.sv
// Shared constants, types and codes for the sample history ring.
package shr_pkg;

    localparam int DEPTH    = 1024;
    localparam int MAX_READ = 64;

    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CAP_W    = $clog2(DEPTH + 1);
    localparam int CNT_W    = $clog2(MAX_READ + 1);
    localparam int SAMPLE_W = 32;
    localparam int FUNC_W   = 2;

    localparam logic [CAP_W-1:0] DEPTH_CAP    = CAP_W'(DEPTH);
    localparam logic [CNT_W-1:0] MAX_READ_CNT = CNT_W'(MAX_READ);

    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [CAP_W-1:0]    t_cap;
    typedef logic [CNT_W-1:0]    t_cnt;
    typedef logic [SAMPLE_W-1:0] t_sample;

    // Operation codes carried by a request word
    typedef enum logic [FUNC_W-1:0] {
        FN_WRITE = 2'd0,
        FN_READ  = 2'd1,
        FN_CLEAR = 2'd2,
        FN_NONE  = 2'd3
    } t_func;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    // One write port and one read port of the sample store
    typedef struct packed {
        logic    we;
        t_addr   waddr;
        t_sample wdata;
        logic    re;
        t_addr   raddr;
    } t_mem_req;

endpackage

### rtl/core/shr_store.sv
// Sample store: one write port, one read port, registered read data.
module shr_store (
    input  logic              i_clk,
    input  shr_pkg::t_mem_req i_req,
    output shr_pkg::t_sample  o_rd_data
);

    shr_pkg::t_sample r_mem [shr_pkg::DEPTH];
    shr_pkg::t_sample r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Read port; data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/sample_history_ring_top.sv
// Sample history ring: circular store of sample words with read-latest runs.
// Write and clear words: one per cycle while input ready is high, no result. Capacity writes also clear.
// Read of N samples: the word enters the read state, which reads the store into the
// registered read data; results follow one per cycle unless the result side stalls.
// Input ready is low during the run, also for an empty read (one result, no data).
// Synchronous active-low reset: position 0, fill 0, capacity 1024; store not cleared.
module sample_history_ring_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [shr_pkg::CAP_W-1:0]   i_cfg_data,
    // request channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [shr_pkg::FUNC_W-1:0]  i_func,
    input  logic [31:0]                 i_sample_in,
    input  logic [6:0]                  i_read_count,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [31:0]                 o_sample_out,
    output logic [6:0]                  o_returned_count,
    output logic                        o_has_sample,
    output logic                        o_last_of_run
);

    shr_pkg::t_state  r_state, n_state;
    shr_pkg::t_addr   r_wp, n_wp;
    shr_pkg::t_cap    r_fill, n_fill;
    shr_pkg::t_cap    r_cap, n_cap;
    shr_pkg::t_addr   r_addr, n_addr;
    shr_pkg::t_cnt    r_left, n_left;
    shr_pkg::t_cnt    r_cnt, n_cnt;
    logic             r_empty, n_empty;
    logic             r_out_valid, n_out_valid;
    logic             r_out_has, n_out_has;
    logic             r_out_last, n_out_last;
    shr_pkg::t_cnt    r_out_cnt, n_out_cnt;

    shr_pkg::t_mem_req mem_req;
    shr_pkg::t_sample  rd_data;
    shr_pkg::t_func    func;

    logic              in_acc;
    logic              cfg_acc;
    logic              advance;
    shr_pkg::t_cnt     req_sat;
    shr_pkg::t_cnt     run_len;
    logic [shr_pkg::CAP_W:0] start_sum;
    shr_pkg::t_cap     wp_inc;
    shr_pkg::t_cap     addr_inc;

    // a pending capacity write goes first; the request word waits
    assign o_cfg_ready = (r_state == shr_pkg::ST_IDLE);
    assign o_in_ready  = (r_state == shr_pkg::ST_IDLE) && !i_cfg_valid;

    assign func    = shr_pkg::t_func'(i_func);
    assign in_acc  = i_in_valid && o_in_ready;
    assign cfg_acc = i_cfg_valid && o_cfg_ready;
    // result register is free or being taken this cycle
    assign advance = !r_out_valid || i_out_ready;

    shr_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    // Read setup: clamp the count, find the oldest entry of the run
    always_comb begin
        req_sat = (shr_pkg::t_cnt'(i_read_count) > shr_pkg::MAX_READ_CNT) ?
                  shr_pkg::MAX_READ_CNT : shr_pkg::t_cnt'(i_read_count);
        run_len = (r_fill < shr_pkg::CAP_W'(req_sat)) ?
                  shr_pkg::t_cnt'(r_fill) : req_sat;
        if (shr_pkg::CAP_W'(r_wp) >= shr_pkg::CAP_W'(run_len)) begin
            start_sum = (shr_pkg::CAP_W + 1)'(r_wp) - (shr_pkg::CAP_W + 1)'(run_len);
        end else begin
            start_sum = (shr_pkg::CAP_W + 1)'(r_wp) + (shr_pkg::CAP_W + 1)'(r_cap)
                      - (shr_pkg::CAP_W + 1)'(run_len);
        end
        wp_inc   = shr_pkg::CAP_W'(r_wp) + shr_pkg::CAP_W'(1);
        addr_inc = shr_pkg::CAP_W'(r_addr) + shr_pkg::CAP_W'(1);
    end

    // Store access
    always_comb begin
        mem_req.we    = in_acc && (func == shr_pkg::FN_WRITE);
        mem_req.waddr = r_wp;
        mem_req.wdata = i_sample_in;
        mem_req.re    = (r_state == shr_pkg::ST_READ) && advance && !r_empty;
        mem_req.raddr = r_addr;
    end

    // Next state and control
    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_fill      = r_fill;
        n_cap       = r_cap;
        n_addr      = r_addr;
        n_left      = r_left;
        n_cnt       = r_cnt;
        n_empty     = r_empty;
        n_out_valid = r_out_valid;
        n_out_has   = r_out_has;
        n_out_last  = r_out_last;
        n_out_cnt   = r_out_cnt;

        if (advance) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            shr_pkg::ST_IDLE: begin
                if (cfg_acc) begin
                    if (i_cfg_data == '0) begin
                        n_cap = shr_pkg::t_cap'(1);
                    end else if (i_cfg_data > shr_pkg::DEPTH_CAP) begin
                        n_cap = shr_pkg::DEPTH_CAP;
                    end else begin
                        n_cap = i_cfg_data;
                    end
                    n_wp   = '0;
                    n_fill = '0;
                end else if (in_acc) begin
                    unique case (func)
                        shr_pkg::FN_WRITE: begin
                            n_wp = (wp_inc == r_cap) ? '0 : shr_pkg::t_addr'(wp_inc);
                            if (r_fill < r_cap) begin
                                n_fill = r_fill + shr_pkg::t_cap'(1);
                            end
                        end
                        shr_pkg::FN_CLEAR: begin
                            n_wp   = '0;
                            n_fill = '0;
                        end
                        shr_pkg::FN_READ: begin
                            n_state = shr_pkg::ST_READ;
                            n_addr  = shr_pkg::t_addr'(start_sum);
                            n_left  = run_len;
                            n_cnt   = run_len;
                            n_empty = (run_len == '0);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            shr_pkg::ST_READ: begin
                if (advance) begin
                    n_out_valid = 1'b1;
                    n_out_cnt   = r_cnt;
                    if (r_empty) begin
                        n_out_has  = 1'b0;
                        n_out_last = 1'b1;
                        n_state    = shr_pkg::ST_IDLE;
                    end else begin
                        n_out_has  = 1'b1;
                        n_out_last = (r_left == shr_pkg::t_cnt'(1));
                        n_left     = r_left - shr_pkg::t_cnt'(1);
                        n_addr     = (addr_inc == r_cap) ? '0 : shr_pkg::t_addr'(addr_inc);
                        if (r_left == shr_pkg::t_cnt'(1)) begin
                            n_state = shr_pkg::ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = shr_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= shr_pkg::ST_IDLE;
            r_wp        <= '0;
            r_fill      <= '0;
            r_cap       <= shr_pkg::DEPTH_CAP;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_fill      <= n_fill;
            r_cap       <= n_cap;
            r_out_valid <= n_out_valid;
        end
    end

    // Run and result payload registers
    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_left     <= n_left;
        r_cnt      <= n_cnt;
        r_empty    <= n_empty;
        r_out_has  <= n_out_has;
        r_out_last <= n_out_last;
        r_out_cnt  <= n_out_cnt;
    end

    assign o_out_valid      = r_out_valid;
    assign o_sample_out     = r_out_has ? rd_data : '0;
    assign o_returned_count = r_out_cnt;
    assign o_has_sample     = r_out_has;
    assign o_last_of_run    = r_out_last;

endmodule

### rtl/core/sample_history_ring_chk.sv
// Port-level checks for the sample history ring, bound to the top level.
module sample_history_ring_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_sample_out,
    input logic [6:0]  o_returned_count,
    input logic        o_has_sample,
    input logic        o_last_of_run
);

    // stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_sample_out)
            && $stable(o_last_of_run))
        else $error("result word changed while stalled");

    // empty read is a single marked word with zero count and data
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_sample |-> o_last_of_run && (o_returned_count == 7'd0)
            && (o_sample_out == 32'd0))
        else $error("malformed empty read result");

    // data words carry a count in range
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_has_sample |-> (o_returned_count != 7'd0)
            && (o_returned_count <= 7'(shr_pkg::MAX_READ)))
        else $error("returned count out of range");

    // reset empties the result register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind sample_history_ring_top sample_history_ring_chk u_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_sample_out     (o_sample_out),
    .o_returned_count (o_returned_count),
    .o_has_sample     (o_has_sample),
    .o_last_of_run    (o_last_of_run)
);
